@@ hdl/gtpv2hp_pkg.sv @@
package gtpv2hp_pkg;

    localparam int POS_W = 17;

    localparam logic [POS_W-1:0] POS_MAX       = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] HDR_LEN_SHORT = POS_W'(8);
    localparam logic [POS_W-1:0] HDR_LEN_LONG  = POS_W'(12);
    localparam logic [POS_W-1:0] LEN_BIAS      = POS_W'(4);

    localparam logic [2:0] GTP_VERSION = 3'd2;
    localparam int         TFLAG_BIT   = 3;

    localparam logic [7:0] CAUSE_RESET = 8'd2;
    localparam logic [7:0] FTEID_RESET = 8'd87;
    localparam logic [7:0] RAT_RESET   = 8'd82;

    // configuration register indexes
    localparam logic [1:0] CFG_CAUSE = 2'd0;
    localparam logic [1:0] CFG_FTEID = 2'd1;
    localparam logic [1:0] CFG_RAT   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_GTPV2  = 2'd1;
    localparam logic [1:0] ST_TEID_SHORT = 2'd2;
    localparam logic [1:0] ST_INCOMPLETE = 2'd3;

    typedef struct packed {
        logic [7:0] cause_type_code;
        logic [7:0] fteid_type_code;
        logic [7:0] rat_type_code;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [1:0]  status;
        logic [7:0]  msg_type;
        logic [31:0] header_teid;
        logic [23:0] seq_num;
        logic [7:0]  ie_type;
        logic [15:0] ie_length;
        logic [3:0]  ie_instance;
        logic [7:0]  cause_value;
        logic [7:0]  rat_value;
        logic [31:0] fteid_value;
        logic [3:0]  found_mask;
    } result_t;

endpackage

@@ hdl/gtpv2hp_cfg.sv @@
module gtpv2hp_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [1:0]           wr_index,
    input  logic [7:0]           wr_data,
    output gtpv2hp_pkg::cfg_t    cfg
);
    import gtpv2hp_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cause_type_code <= CAUSE_RESET;
            cfg_reg.fteid_type_code <= FTEID_RESET;
            cfg_reg.rat_type_code   <= RAT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_CAUSE: cfg_reg.cause_type_code <= wr_data;
                CFG_FTEID: cfg_reg.fteid_type_code <= wr_data;
                CFG_RAT:   cfg_reg.rat_type_code   <= wr_data;
                default:   ; // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/gtpv2hp_engine.sv @@
module gtpv2hp_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            byte_in,
    input  logic                  last_in,
    input  gtpv2hp_pkg::cfg_t     cfg,
    output gtpv2hp_pkg::result_t  res
);
    import gtpv2hp_pkg::*;

    typedef enum logic [4:0] {
        IE_TYPE   = 5'b00001,
        IE_LEN_HI = 5'b00010,
        IE_LEN_LO = 5'b00100,
        IE_INST   = 5'b01000,
        IE_BODY   = 5'b10000
    } ie_state_t;

    logic [POS_W-1:0] pos_reg;
    logic [7:0]       flags_reg,  flags_next;
    logic [7:0]       type_reg,   type_next;
    logic [15:0]      blen_reg,   blen_next;
    logic [31:0]      teid_reg,   teid_next;
    logic [23:0]      seq_reg,    seq_next;
    ie_state_t        ie_reg,     ie_next;
    logic [7:0]       iet_reg,    iet_next;
    logic [15:0]      iel_reg,    iel_next;
    logic [3:0]       iei_reg,    iei_next;
    logic [15:0]      left_reg,   left_next;
    logic             stop_reg,   stop_next;
    logic [7:0]       cause_reg,  cause_next;
    logic [7:0]       rat_reg,    rat_next;
    logic [31:0]      fteid_reg,  fteid_next;
    logic [31:0]      fshift_reg, fshift_next;
    logic [2:0]       found_reg,  found_next;
    logic [7:0]       first_reg,  first_next;

    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] total;
    logic [POS_W-1:0] hdr_len;
    logic             tflag;
    logic             in_walk;
    logic             ie_done;
    logic             overrun;
    logic [15:0]      k_off;
    logic [15:0]      left_dec;
    logic [1:0]       st;

    assign pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
    assign k_off    = iel_reg - left_reg;
    assign left_dec = left_reg - 16'd1;
    assign overrun  = ({1'b0, pos_inc} + {2'b00, iel_reg}) > {1'b0, total};

    always_comb
    begin
        flags_next  = flags_reg;
        type_next   = type_reg;
        blen_next   = blen_reg;
        teid_next   = teid_reg;
        seq_next    = seq_reg;
        ie_next     = ie_reg;
        iet_next    = iet_reg;
        iel_next    = iel_reg;
        iei_next    = iei_reg;
        left_next   = left_reg;
        stop_next   = stop_reg;
        cause_next  = cause_reg;
        rat_next    = rat_reg;
        fteid_next  = fteid_reg;
        fshift_next = fshift_reg;
        found_next  = found_reg;
        first_next  = first_reg;
        ie_done     = 1'b0;

        // fixed header bytes
        if (pos_reg == POS_W'(0))
            flags_next = byte_in;
        if (pos_reg == POS_W'(1))
            type_next = byte_in;
        if (pos_reg == POS_W'(2))
            blen_next = {byte_in, blen_reg[7:0]};
        if (pos_reg == POS_W'(3))
            blen_next = {blen_reg[15:8], byte_in};

        tflag   = flags_next[TFLAG_BIT];
        hdr_len = tflag ? HDR_LEN_LONG : HDR_LEN_SHORT;
        total   = {1'b0, blen_next} + LEN_BIAS;

        if (tflag)
        begin
            if (pos_reg >= POS_W'(4) && pos_reg <= POS_W'(7))
                teid_next = {teid_reg[23:0], byte_in};
            else if (pos_reg >= POS_W'(8) && pos_reg <= POS_W'(10))
                seq_next = {seq_reg[15:0], byte_in};
        end
        else if (pos_reg >= POS_W'(4) && pos_reg <= POS_W'(6))
        begin
            seq_next = {seq_reg[15:0], byte_in};
        end

        // IE walk
        in_walk = !stop_reg && (pos_reg >= hdr_len) && (pos_reg < total);
        if (in_walk)
        begin
            case (ie_reg)
                IE_TYPE:
                begin
                    iet_next = byte_in;
                    iel_next = 16'd0;
                    iei_next = 4'd0;
                    ie_next  = IE_LEN_HI;
                end
                IE_LEN_HI:
                begin
                    iel_next = {byte_in, 8'd0};
                    ie_next  = IE_LEN_LO;
                end
                IE_LEN_LO:
                begin
                    iel_next = {iel_reg[15:8], byte_in};
                    ie_next  = IE_INST;
                end
                IE_INST:
                begin
                    iei_next    = byte_in[7:4];
                    first_next  = 8'd0;
                    fshift_next = 32'd0;
                    if (overrun)
                    begin
                        stop_next = 1'b1;
                        ie_next   = IE_TYPE;
                    end
                    else if (iel_reg == 16'd0)
                    begin
                        ie_done = 1'b1;
                        ie_next = IE_TYPE;
                    end
                    else
                    begin
                        left_next = iel_reg;
                        ie_next   = IE_BODY;
                    end
                end
                IE_BODY:
                begin
                    if (k_off == 16'd0)
                        first_next = byte_in;
                    else if (k_off <= 16'd4)
                        fshift_next = {fshift_reg[23:0], byte_in};
                    left_next = left_dec;
                    if (left_dec == 16'd0)
                    begin
                        ie_done = 1'b1;
                        ie_next = IE_TYPE;
                    end
                end
                default:
                begin
                    ie_next = IE_TYPE;
                end
            endcase
        end

        // captures, each type code checked on its own
        if (ie_done)
        begin
            if (iet_next == cfg.cause_type_code && iel_next >= 16'd2)
            begin
                cause_next    = first_next;
                found_next[0] = 1'b1;
            end
            if (iet_next == cfg.rat_type_code && iel_next >= 16'd1)
            begin
                rat_next      = first_next;
                found_next[2] = 1'b1;
            end
            if (iet_next == cfg.fteid_type_code && iel_next >= 16'd5)
            begin
                fteid_next    = fshift_next;
                found_next[1] = 1'b1;
            end
        end

        if (pos_inc < HDR_LEN_SHORT || flags_next[7:5] != GTP_VERSION)
            st = ST_NOT_GTPV2;
        else if (tflag && pos_inc < HDR_LEN_LONG)
            st = ST_TEID_SHORT;
        else if (pos_inc < total)
            st = ST_INCOMPLETE;
        else
            st = ST_OK;

        res.event_res   = {last_in, ie_done};
        res.status      = last_in ? st : ST_OK;
        res.msg_type    = type_next;
        res.header_teid = tflag ? teid_next : 32'd0;
        res.seq_num     = seq_next;
        res.ie_type     = ie_done ? iet_next : 8'd0;
        res.ie_length   = ie_done ? iel_next : 16'd0;
        res.ie_instance = ie_done ? iei_next : 4'd0;
        res.cause_value = cause_next;
        res.rat_value   = rat_next;
        res.fteid_value = fteid_next;
        res.found_mask  = {found_next, tflag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            flags_reg  <= '0;
            type_reg   <= '0;
            blen_reg   <= '0;
            teid_reg   <= '0;
            seq_reg    <= '0;
            ie_reg     <= IE_TYPE;
            iet_reg    <= '0;
            iel_reg    <= '0;
            iei_reg    <= '0;
            left_reg   <= '0;
            stop_reg   <= 1'b0;
            cause_reg  <= '0;
            rat_reg    <= '0;
            fteid_reg  <= '0;
            fshift_reg <= '0;
            found_reg  <= '0;
            first_reg  <= '0;
        end
        else if (step)
        begin
            if (last_in)
            begin
                // packet done: everything back to its reset value
                pos_reg    <= '0;
                flags_reg  <= '0;
                type_reg   <= '0;
                blen_reg   <= '0;
                teid_reg   <= '0;
                seq_reg    <= '0;
                ie_reg     <= IE_TYPE;
                iet_reg    <= '0;
                iel_reg    <= '0;
                iei_reg    <= '0;
                left_reg   <= '0;
                stop_reg   <= 1'b0;
                cause_reg  <= '0;
                rat_reg    <= '0;
                fteid_reg  <= '0;
                fshift_reg <= '0;
                found_reg  <= '0;
                first_reg  <= '0;
            end
            else
            begin
                pos_reg    <= pos_inc;
                flags_reg  <= flags_next;
                type_reg   <= type_next;
                blen_reg   <= blen_next;
                teid_reg   <= teid_next;
                seq_reg    <= seq_next;
                ie_reg     <= ie_next;
                iet_reg    <= iet_next;
                iel_reg    <= iel_next;
                iei_reg    <= iei_next;
                left_reg   <= left_next;
                stop_reg   <= stop_next;
                cause_reg  <= cause_next;
                rat_reg    <= rat_next;
                fteid_reg  <= fteid_next;
                fshift_reg <= fshift_next;
                found_reg  <= found_next;
                first_reg  <= first_next;
            end
        end
    end

    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> ie_reg == IE_TYPE)
        else $error("walk stopped with IE header part-read");

    a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
        ie_reg == IE_BODY |-> left_reg != 16'd0 && left_reg <= iel_reg)
        else $error("IE body count out of range");

    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_in |=> pos_reg == '0 && found_reg == '0 && !stop_reg)
        else $error("packet state not cleared after final byte");

endmodule

@@ hdl/gtpv2_header_ie_stream_parser_core.sv @@
// GTPv2-C header and IE parser. Bytes of one message enter on the input
// channel, one per transfer, with last_byte set on the final byte. The block
// decodes flags, message type, length, optional TEID and the 24-bit sequence
// number, then walks the type-length-instance IEs up to 4+length bytes. A
// result is produced for each completed IE (event_res bit 0) and for the final
// byte (event_res bit 1, with status); both may share one result. Bytes that
// complete nothing produce no result. Records of a bad packet are still sent
// and should be dropped downstream by the summary status. Throughput is one
// byte per clock while results are taken: an input register stages each byte
// and combinational decode logic loads the result register from it, which
// offers the result. While a result waits for out_ready the staged byte
// holds; one more byte can fill an empty input register, then the input
// stalls until the result is taken.
// The three IE type codes (Cause, F-TEID, RAT type) are set through the
// configuration channel, indexes 0, 1 and 2; write them only while idle.
module gtpv2_header_ie_stream_parser_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_res,
    output logic [1:0]  status,
    output logic [7:0]  msg_type,
    output logic [31:0] header_teid,
    output logic [23:0] seq_num,
    output logic [7:0]  ie_type,
    output logic [15:0] ie_length,
    output logic [3:0]  ie_instance,
    output logic [7:0]  cause_value,
    output logic [7:0]  rat_value,
    output logic [31:0] fteid_value,
    output logic [3:0]  found_mask
);
    import gtpv2hp_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t res_reg;

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       out_valid_reg, out_valid_next;
    logic       in_xfer;
    logic       advance;
    logic       has_result;

    // config writes always taken
    assign cfg_ready = 1'b1;

    gtpv2hp_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // input stage moves on whenever the result slot is free or draining
    assign advance    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || advance;
    assign in_xfer    = in_valid && in_ready;
    assign has_result = res.event_res != 2'b00;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && has_result)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_byte_reg <= byte_value;
            s1_last_reg <= last_byte;
        end
        if (advance && has_result)
            res_reg <= res;
    end

    gtpv2hp_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (s1_byte_reg),
        .last_in (s1_last_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign out_valid   = out_valid_reg;
    assign event_res   = res_reg.event_res;
    assign status      = res_reg.status;
    assign msg_type    = res_reg.msg_type;
    assign header_teid = res_reg.header_teid;
    assign seq_num     = res_reg.seq_num;
    assign ie_type     = res_reg.ie_type;
    assign ie_length   = res_reg.ie_length;
    assign ie_instance = res_reg.ie_instance;
    assign cause_value = res_reg.cause_value;
    assign rat_value   = res_reg.rat_value;
    assign fteid_value = res_reg.fteid_value;
    assign found_mask  = res_reg.found_mask;

    a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("staged byte lost while stalled");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance && has_result |=> out_valid_reg)
        else $error("result dropped");

    a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> res_reg.event_res != 2'b00)
        else $error("result without event");

endmodule
